/* hw/rtl/tpd_pkg.sv */
// ----------------------------------------------------------------------------
// tpd_pkg - shared types and constants for the thermal presence detector
// Field widths, register reset values, opcodes and the constants of the
// ambient divider (floored division by the calibration pixel total).
// ----------------------------------------------------------------------------
`default_nettype none

package tpd_pkg;

  // Frame geometry and calibration length
  localparam int PIXELS       = 64;
  localparam int CALIB_FRAMES = 10;

  // Field widths
  localparam int TEMP_W = 12;
  localparam int THR_W  = 9;
  localparam int MINP_W = 7;
  localparam int CNT_W  = 7;
  localparam int MAX_W  = 11;
  localparam int SUM_W  = 22;
  localparam int FRM_W  = 4;
  localparam int CFG_W  = THR_W;

  // Register reset values
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(8);
  localparam logic [MINP_W-1:0] MINP_RESET = MINP_W'(4);

  // Ambient divider: u = sum + K*D is never negative, floor(u/D) by
  // reciprocal multiply with one correction step, then K taken off.
  localparam int DIV_D  = PIXELS * CALIB_FRAMES;
  localparam int DIV_W  = 14;
  localparam int U_W    = 23;
  localparam int M_W    = 24;
  localparam int DIV_SH = 23;
  localparam int DIV_K  = ((2 ** (SUM_W - 1)) + DIV_D - 1) / DIV_D;
  localparam int DIV_BIAS = DIV_K * DIV_D;
  localparam int DIV_M  = (2 ** DIV_SH) / DIV_D;

  typedef enum logic {
    OP_DETECT = 1'b0,
    OP_CALIB  = 1'b1
  } opcode_t;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_MIN_HOT   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    opcode_t                  op;
    logic signed [TEMP_W-1:0] pix;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic                     presence;
    logic [CNT_W-1:0]         count;
    logic [MAX_W-1:0]         max_temp;
    logic signed [TEMP_W-1:0] ambient;
    logic                     rose;
    logic                     fell;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/tpd_div.sv */
// ----------------------------------------------------------------------------
// tpd_div - ambient divider
// Floored division of the saturated calibration sum by the pixel total,
// clamped to the temperature range. Four register stages, result held
// until acknowledged.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_div
  import tpd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [SUM_W-1:0]  sum,
  input  wire logic                     ack,
  output logic                          done,
  output logic signed [TEMP_W-1:0]      amb
);

  localparam logic signed [U_W+1:0] Q_HI = (U_W+2)'((2 ** (TEMP_W - 1)) - 1);
  localparam logic signed [U_W+1:0] Q_LO = -(U_W+2)'(2 ** (TEMP_W - 1));

  logic                     p0, p1, p2, p3;
  logic signed [SUM_W-1:0]  s_r;
  logic [U_W-1:0]           u1, u2, u3;
  logic [U_W-1:0]           qe2, qe3;
  logic [U_W-1:0]           qd3;

  logic [U_W:0]             u_sum;
  logic [U_W+M_W-1:0]       prod;
  logic [U_W+DIV_W-1:0]     qd_full;
  logic [U_W-1:0]           rem;
  logic                     corr;
  logic signed [U_W+1:0]    qf;

  // bias the sum so that it is never negative
  assign u_sum = {{(U_W+1-SUM_W){s_r[SUM_W-1]}}, s_r} + (U_W+1)'(DIV_BIAS);

  // reciprocal estimate, low by at most one
  assign prod = (U_W+M_W)'(u1) * (U_W+M_W)'(DIV_M);

  // back-multiply for the remainder
  assign qd_full = (U_W+DIV_W)'(qe2) * (U_W+DIV_W)'(DIV_D);

  // correction, unbias and clamp
  assign rem  = u3 - qd3;
  assign corr = (rem >= U_W'(DIV_D));
  assign qf   = $signed({2'b00, qe3}) + $signed({(U_W+1)'(0), corr})
              - $signed((U_W+2)'(DIV_K));

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      p0   <= 1'b0;
      p1   <= 1'b0;
      p2   <= 1'b0;
      p3   <= 1'b0;
      done <= 1'b0;
    end else begin
      p0 <= start;
      p1 <= p0;
      p2 <= p1;
      p3 <= p2;
      if (p3) begin
        done <= 1'b1;
      end else if (ack) begin
        done <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      s_r <= sum;
    end
    u1  <= u_sum[U_W-1:0];
    u2  <= u1;
    qe2 <= prod[DIV_SH +: U_W];
    u3  <= u2;
    qe3 <= qe2;
    qd3 <= qd_full[U_W-1:0];
    if (p3) begin
      if (qf > Q_HI) begin
        amb <= Q_HI[TEMP_W-1:0];
      end else if (qf < Q_LO) begin
        amb <= Q_LO[TEMP_W-1:0];
      end else begin
        amb <= qf[TEMP_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tpd_accum.sv */
// ----------------------------------------------------------------------------
// tpd_accum - per-pixel accumulation and frame status
// Hot-pixel count and maximum for detect frames, saturating sum and frame
// count for calibration, presence edges and the ambient level.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_accum
  import tpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_v,
  input  wire item_t              item,
  input  wire logic [THR_W-1:0]   thr,
  input  wire logic [MINP_W-1:0]  min_hot,
  input  wire logic               out_can_load,
  output logic                    fire,
  output logic                    res_load,
  output res_t                    res
);

  localparam logic signed [SUM_W:0] SUM_HI = (SUM_W+1)'((2 ** (SUM_W - 1)) - 1);
  localparam logic signed [SUM_W:0] SUM_LO = -(SUM_W+1)'(2 ** (SUM_W - 1));

  logic signed [TEMP_W-1:0] ambient;
  logic                     presence_flag;
  logic [CNT_W-1:0]         hot_cnt;
  logic [MAX_W-1:0]         run_max;
  logic [CNT_W-1:0]         last_cnt;
  logic [MAX_W-1:0]         last_max;
  logic signed [SUM_W-1:0]  cal_sum;
  logic [FRM_W-1:0]         frames;
  logic                     busy;

  logic signed [TEMP_W+1:0] thr_level;
  logic                     is_det, is_cal, hot;
  logic [CNT_W-1:0]         cnt_fin;
  logic [MAX_W-1:0]         max_fin;
  logic                     presence_new;
  logic signed [SUM_W:0]    sum_add;
  logic signed [SUM_W-1:0]  sum_sat;
  logic [FRM_W-1:0]         frames_inc;
  logic                     cal_end, div_start, div_done, div_ack;
  logic signed [TEMP_W-1:0] div_amb;

  // hot test against ambient plus margin
  assign is_det    = (item.op == OP_DETECT);
  assign is_cal    = (item.op == OP_CALIB);
  assign thr_level = (TEMP_W+2)'(ambient) + $signed({2'b00, 3'b000, thr});
  assign hot       = is_det && ((TEMP_W+2)'(item.pix) > thr_level);

  // count saturates, maximum only follows positive pixels
  assign cnt_fin = (hot && (hot_cnt != '1)) ? hot_cnt + CNT_W'(1) : hot_cnt;
  assign max_fin = (hot && !item.pix[TEMP_W-1] && (item.pix[MAX_W-1:0] > run_max))
                 ? item.pix[MAX_W-1:0] : run_max;
  assign presence_new = (cnt_fin >= min_hot);

  // calibration sum, saturating
  assign sum_add = (SUM_W+1)'(cal_sum) + (SUM_W+1)'(item.pix);
  always_comb begin
    if (sum_add > SUM_HI) begin
      sum_sat = SUM_HI[SUM_W-1:0];
    end else if (sum_add < SUM_LO) begin
      sum_sat = SUM_LO[SUM_W-1:0];
    end else begin
      sum_sat = sum_add[SUM_W-1:0];
    end
  end
  assign frames_inc = frames + FRM_W'(1);
  assign cal_end    = (frames_inc >= FRM_W'(CALIB_FRAMES));

  // handshake with the input and output registers
  assign fire      = in_v && !busy && !(is_det && item.last && !out_can_load);
  assign div_start = fire && is_cal && item.last && cal_end;
  assign div_ack   = div_done && out_can_load;
  assign res_load  = (fire && is_det && item.last) || div_ack;

  // result word
  always_comb begin
    if (div_done) begin
      res.presence = presence_flag;
      res.count    = last_cnt;
      res.max_temp = last_max;
      res.ambient  = div_amb;
      res.rose     = 1'b0;
      res.fell     = 1'b0;
    end else begin
      res.presence = presence_new;
      res.count    = cnt_fin;
      res.max_temp = max_fin;
      res.ambient  = ambient;
      res.rose     = presence_new && !presence_flag;
      res.fell     = !presence_new && presence_flag;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      ambient       <= '0;
      presence_flag <= 1'b0;
      hot_cnt       <= '0;
      run_max       <= '0;
      last_cnt      <= '0;
      last_max      <= '0;
      cal_sum       <= '0;
      frames        <= '0;
      busy          <= 1'b0;
    end else begin
      if (fire && is_det) begin
        if (item.last) begin
          presence_flag <= presence_new;
          last_cnt      <= cnt_fin;
          last_max      <= max_fin;
          hot_cnt       <= '0;
          run_max       <= '0;
        end else begin
          hot_cnt <= cnt_fin;
          run_max <= max_fin;
        end
      end
      if (fire && is_cal) begin
        if (div_start) begin
          cal_sum <= '0;
          frames  <= '0;
          busy    <= 1'b1;
        end else begin
          cal_sum <= sum_sat;
          if (item.last) begin
            frames <= frames_inc;
          end
        end
      end
      if (div_ack) begin
        ambient <= div_amb;
        busy    <= 1'b0;
      end
    end
  end

  tpd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (sum_sat),
    .ack   (div_ack),
    .done  (div_done),
    .amb   (div_amb)
  );

`ifndef SYNTHESIS
  // nothing is taken while the ambient division is pending
  a_busy_stall: assert property (@(posedge clk) disable iff (rst) busy |-> !fire)
    else $error("pixel consumed during ambient division");
  // a result is only loaded into a free output register
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_can_load)
    else $error("result loaded over a waiting result");
  // the divider only finishes inside a calibration hold
  a_done_busy: assert property (@(posedge clk) disable iff (rst) div_done |-> busy)
    else $error("divider result without pending calibration");
  // a rising edge reports presence and never a falling one
  a_edge: assert property (@(posedge clk) disable iff (rst)
    (res_load && res.rose) |-> (res.presence && !res.fell))
    else $error("inconsistent presence edge");
`endif

endmodule

`default_nettype wire

/* hw/rtl/thermal_presence_detector_top.sv */
// ----------------------------------------------------------------------------
// thermal_presence_detector_top - thermal array presence detector
// Input register, configuration registers, accumulation core and output
// register.
// ----------------------------------------------------------------------------
// Pixels are taken at one per clock while nothing holds them. A detect frame's
// status word is loaded into the output register on the edge that takes its
// last pixel from the input register. While a status word waits to be taken,
// pixels keep flowing; only a detect pixel that ends a frame is held until
// the output register frees. After the final calibration frame the ambient
// average goes through a four-stage reciprocal divider: the input takes one
// more pixel and then none until the divider result is acknowledged, and the
// calibration status word is loaded with that acknowledge. A full output
// register stretches both waits. Configuration writes take effect at the
// next clock edge.
`default_nettype none

module thermal_presence_detector_top
  import tpd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  // pixel stream
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     opcode,
  input  wire logic signed [TEMP_W-1:0] pixel_temp,
  input  wire logic                     last_of_frame,
  // frame status
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          presence,
  output logic [CNT_W-1:0]              hot_pixel_count,
  output logic [MAX_W-1:0]              max_hot_temp,
  output logic signed [TEMP_W-1:0]      ambient_temp,
  output logic                          presence_rose,
  output logic                          presence_fell
);

  logic [THR_W-1:0]  temp_threshold;
  logic [MINP_W-1:0] min_hot_pixels;
  logic              in_v;
  item_t             item_r;
  res_t              res_r;
  res_t              res;
  logic              fire, res_load, out_can_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_threshold <= THR_RESET;
      min_hot_pixels <= MINP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: temp_threshold <= cfg_data[THR_W-1:0];
        CFG_MIN_HOT:   min_hot_pixels <= cfg_data[MINP_W-1:0];
        default:       ;
      endcase
    end
  end

  // input register
  assign in_ready = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v <= 1'b1;
    end else if (fire) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.op   <= opcode_t'(opcode);
      item_r.pix  <= pixel_temp;
      item_r.last <= last_of_frame;
    end
  end

  tpd_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .in_v         (in_v),
    .item         (item_r),
    .thr          (temp_threshold),
    .min_hot      (min_hot_pixels),
    .out_can_load (out_can_load),
    .fire         (fire),
    .res_load     (res_load),
    .res          (res)
  );

  // output register
  assign out_can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign presence        = res_r.presence;
  assign hot_pixel_count = res_r.count;
  assign max_hot_temp    = res_r.max_temp;
  assign ambient_temp    = res_r.ambient;
  assign presence_rose   = res_r.rose;
  assign presence_fell   = res_r.fell;

endmodule

`default_nettype wire

/* bench/tb_thermal_presence_detector_top.sv */
// ----------------------------------------------------------------------------
// tb_thermal_presence_detector_top - self-checking bench for the detector
// Streams detect and calibration pixels through the block under random
// handshake pressure and works out each frame status word in a local copy
// of the detector's state. Status words are compared field by field, in
// order, with the words predicted when their frame's last pixel was taken.
// ----------------------------------------------------------------------------

module tb_thermal_presence_detector_top;
  import tpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 12;     // calibration divider plus output stage
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SAT_FRAME_LEN = 105;    // ten of these overflow the sum

  typedef struct {
    item_t word;
    bit    drain;   // hold this word back until every status word is out
  } pending_t;

  // DUT connections
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic                     cfg_index = 1'b0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     opcode = 1'b0;
  logic signed [TEMP_W-1:0] pixel_temp = '0;
  logic                     last_of_frame = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     presence;
  logic [CNT_W-1:0]         hot_pixel_count;
  logic [MAX_W-1:0]         max_hot_temp;
  logic signed [TEMP_W-1:0] ambient_temp;
  logic                     presence_rose;
  logic                     presence_fell;

  // Stimulus and expectations
  pending_t pixel_pending[$];
  res_t     status_expected[$];
  pending_t next_word;
  item_t    word_on_bus;
  res_t     due_status;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       mismatches = 0;
  int       cycle_count = 0;

  // Local copy of the detector state
  logic [THR_W-1:0]         thr_cfg = THR_RESET;
  logic [MINP_W-1:0]        minp_cfg = MINP_RESET;
  logic signed [TEMP_W-1:0] ambient_q = '0;
  logic                     presence_q = 1'b0;
  logic [CNT_W-1:0]         hot_run = '0;
  int                       max_run = 0;
  longint                   calib_sum = 0;
  logic [FRM_W-1:0]         calib_frames = '0;
  logic [CNT_W-1:0]         frame_count_q = '0;
  int                       frame_max_q = 0;

  thermal_presence_detector_top uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .pixel_temp      (pixel_temp),
    .last_of_frame   (last_of_frame),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .presence        (presence),
    .hot_pixel_count (hot_pixel_count),
    .max_hot_temp    (max_hot_temp),
    .ambient_temp    (ambient_temp),
    .presence_rose   (presence_rose),
    .presence_fell   (presence_fell)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Frame status prediction, run once per accepted pixel
  task automatic predict_status(item_t w);
    int     pix;
    bit     was;
    longint den;
    longint q;
    res_t   e;
    pix = int'($signed(w.pix));
    e = '0;
    if (w.op == OP_DETECT) begin
      if (pix > int'(ambient_q) + int'(thr_cfg)) begin
        if (hot_run != 7'd127) hot_run++;
        if (pix > max_run) max_run = pix;
      end
      if (w.last) begin
        was = presence_q;
        presence_q = (hot_run >= minp_cfg);
        frame_count_q = hot_run;
        frame_max_q = max_run;
        hot_run = '0;
        max_run = 0;
        e.presence = presence_q;
        e.count = frame_count_q;
        e.max_temp = frame_max_q[MAX_W-1:0];
        e.ambient = ambient_q;
        e.rose = presence_q && !was;
        e.fell = !presence_q && was;
        status_expected.push_back(e);
      end
    end else begin
      // saturating 22-bit signed sum
      calib_sum += pix;
      if (calib_sum > 64'sd2097151) calib_sum = 64'sd2097151;
      if (calib_sum < -64'sd2097152) calib_sum = -64'sd2097152;
      if (w.last) begin
        calib_frames++;
        if (int'(calib_frames) >= CALIB_FRAMES) begin
          den = longint'(PIXELS) * longint'(CALIB_FRAMES);
          // floored average, clamped to the temperature range
          if (calib_sum >= 0) q = calib_sum / den;
          else q = -((-calib_sum + den - 1) / den);
          if (q > 2047) q = 2047;
          if (q < -2048) q = -2048;
          ambient_q = TEMP_W'(q);
          calib_sum = 0;
          calib_frames = '0;
          e.presence = presence_q;
          e.count = frame_count_q;
          e.max_temp = frame_max_q[MAX_W-1:0];
          e.ambient = ambient_q;
          status_expected.push_back(e);
        end
      end
    end
  endtask

  function automatic logic signed [TEMP_W-1:0] clip_temp(int v);
    if (v > 2047) return 12'sd2047;
    if (v < -2048) return -12'sd2048;
    return TEMP_W'(v);
  endfunction

  task automatic push_pixel(opcode_t op, int t, bit eof, bit drain);
    pending_t p;
    p.word.op = op;
    p.word.pix = clip_temp(t);
    p.word.last = eof;
    p.drain = drain;
    pixel_pending.push_back(p);
  endtask

  // Quiet means nothing queued, nothing on the bus and no status word due,
  // held for long enough to cover a calibration frame still in the divider
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk);
      if (pixel_pending.size() != 0 || in_valid || status_expected.size() != 0)
        quiet = 0;
      else
        quiet++;
    end
  endtask

  task automatic write_config(int thr, int minp);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_data <= CFG_W'(thr);
    @(posedge clk);
    cfg_index <= CFG_MIN_HOT;
    cfg_data <= CFG_W'(minp);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    thr_cfg = THR_W'(thr);
    minp_cfg = MINP_W'(minp);
  endtask

  // Random frames: mostly short, some full size and a few long ones,
  // with an odd pixel of the other mode mixed in
  task automatic push_random_frames(int budget);
    int      pushed;
    int      len;
    int      r;
    int      v;
    int      base;
    opcode_t kind;
    opcode_t op;
    pushed = 0;
    while (pushed < budget) begin
      kind = ($urandom_range(99) < 30) ? OP_CALIB : OP_DETECT;
      r = int'($urandom_range(99));
      if (r < 70) len = int'($urandom_range(12, 1));
      else if (r < 92) len = int'($urandom_range(64, 13));
      else len = int'($urandom_range(140, 65));
      base = int'(ambient_q) + int'(thr_cfg);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(15) == 0) op = (kind == OP_DETECT) ? OP_CALIB : OP_DETECT;
        else op = kind;
        r = int'($urandom_range(99));
        if (r < 45) v = base + int'($urandom_range(24)) - 12;
        else if (r < 70) v = base + int'($urandom_range(400));
        else v = int'($urandom_range(4095)) - 2048;
        push_pixel(op, v, i == len - 1, i == 0 && $urandom_range(149) == 0);
      end
      pushed += len;
      while (pixel_pending.size() > 16) @(posedge clk);
    end
  endtask

  // Finish any calibration set in progress, then one set of long frames
  // near one end of the range so that the sum saturates
  task automatic push_saturating_calibration(bit high);
    int pads;
    int v;
    wait_idle();
    pads = (calib_frames == 0) ? 0 : CALIB_FRAMES - int'(calib_frames);
    for (int i = 0; i < pads; i++)
      push_pixel(OP_CALIB, int'($urandom_range(4095)) - 2048, 1'b1, 1'b0);
    for (int f = 0; f < CALIB_FRAMES; f++) begin
      for (int i = 0; i < SAT_FRAME_LEN; i++) begin
        if (high) v = int'($urandom_range(2047, 2000));
        else v = -int'($urandom_range(2048, 2000));
        push_pixel(OP_CALIB, v, i == SAT_FRAME_LEN - 1, 1'b0);
      end
    end
  endtask

  // Pixel driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_status(word_on_bus);
      end
      if (!in_valid || in_ready) begin
        if (pixel_pending.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pixel_pending[0].drain && status_expected.size() != 0)) begin
          next_word = pixel_pending.pop_front();
          word_on_bus = next_word.word;
          in_valid <= 1'b1;
          opcode <= next_word.word.op;
          pixel_temp <= next_word.word.pix;
          last_of_frame <= next_word.word.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, longint expd, longint act);
    if (expd != act) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, expd, act);
      mismatches++;
    end
  endfunction

  // Status monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_expected.size() == 0) begin
          $display("%0t ns: status word with none expected", $time);
          mismatches++;
        end else begin
          due_status = status_expected.pop_front();
          check_field("presence", due_status.presence, presence);
          check_field("hot_pixel_count", due_status.count, hot_pixel_count);
          check_field("max_hot_temp", due_status.max_temp, max_hot_temp);
          check_field("ambient_temp", $signed(due_status.ambient), $signed(ambient_temp));
          check_field("presence_rose", due_status.rose, presence_rose);
          check_field("presence_fell", due_status.fell, presence_fell);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 29;
    recv_stall_pct = 63;

    // Directed frames at reset settings: field extremes, threshold edge
    push_pixel(OP_DETECT, 2047, 1'b0, 1'b0);
    push_pixel(OP_DETECT, -2048, 1'b0, 1'b0);
    push_pixel(OP_DETECT, 9, 1'b0, 1'b0);
    push_pixel(OP_DETECT, 8, 1'b0, 1'b0);
    push_pixel(OP_DETECT, 0, 1'b1, 1'b0);
    // presence rises, then falls on a one-pixel frame
    push_pixel(OP_DETECT, 100, 1'b0, 1'b0);
    push_pixel(OP_DETECT, 200, 1'b0, 1'b0);
    push_pixel(OP_DETECT, 300, 1'b0, 1'b0);
    push_pixel(OP_DETECT, 400, 1'b1, 1'b0);
    push_pixel(OP_DETECT, -5, 1'b1, 1'b0);
    // mixed frame closed by a calibration pixel: silent calibration end
    push_pixel(OP_DETECT, 50, 1'b0, 1'b0);
    push_pixel(OP_CALIB, 1000, 1'b0, 1'b0);
    push_pixel(OP_DETECT, 60, 1'b0, 1'b0);
    push_pixel(OP_CALIB, 7, 1'b1, 1'b0);
    // rest of the calibration set, negative sum floors downwards
    for (int i = 0; i < CALIB_FRAMES - 1; i++)
      push_pixel(OP_CALIB, -2048, 1'b1, 1'b0);
    // held pixels of the detect frame carry over; close it after a drain
    push_pixel(OP_DETECT, -19, 1'b1, 1'b1);

    write_config(0, 0);
    push_random_frames(30);
    write_config(400, 64);
    push_random_frames(30);

    write_config(511, 127);
    send_idle_pct = 63;
    recv_stall_pct = 29;
    push_random_frames(30);
    write_config(3, 1);
    push_random_frames(30);

    write_config(20, 10);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_random_frames(30);
    write_config(150, 40);
    push_random_frames(30);

    // Saturated sum and clamped ambient at one end, picked at random
    write_config(0, 127);
    push_saturating_calibration($urandom_range(1) == 1);
    wait_idle();
    // ambient back to zero, then every pixel hot: the count saturates
    for (int i = 0; i < CALIB_FRAMES; i++)
      push_pixel(OP_CALIB, 0, 1'b1, 1'b0);
    for (int i = 0; i < 140; i++)
      push_pixel(OP_DETECT, int'($urandom_range(2047, 1)), i == 139, 1'b0);

    write_config(int'(THR_RESET), int'(MINP_RESET));
    push_random_frames(30);

    wait_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
